// ===== hw/rtl/utv_pkg.sv =====
// utv_pkg: shared types, codes and constants for the UTF-8 text validator.
// No dependencies; used by the channel interfaces, utv_byte_check and the core.
package utv_pkg;

  localparam int unsigned POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [2:0]       pend_t;

  typedef enum logic [2:0] {
    REASON_OK      = 3'd0,
    REASON_SHORT   = 3'd1,
    REASON_LEAD    = 3'd2,
    REASON_OVERRUN = 3'd3,
    REASON_CONT    = 3'd4,
    REASON_CTRL    = 3'd5,
    REASON_NOTERM  = 3'd6
  } reason_t;

  typedef enum logic [0:0] {
    REG_MIN_LENGTH = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] CONT_MASK  = 8'hc0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD_TAG   = 8'hc0;
  localparam logic [7:0] LOW_MASK   = 8'h3f;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef struct packed {
    logic    emit;
    logic    ok;
    reason_t reason;
    pos_t    position;
    pend_t   pend_next;
    pos_t    pos_next;
  } check_t;

  // continuation count announced by a lead byte 11xxxxxx, zero for FE/FF
  function automatic pend_t cont_count(input logic [7:0] b);
    logic [7:0] low;
    low = b & LOW_MASK;
    if (low < 8'h20)      cont_count = 3'd1;
    else if (low < 8'h30) cont_count = 3'd2;
    else if (low < 8'h38) cont_count = 3'd3;
    else if (low < 8'h3c) cont_count = 3'd4;
    else if (low < 8'h3e) cont_count = 3'd5;
    else                  cont_count = 3'd0;
  endfunction

endpackage

// ===== hw/rtl/utv_if.sv =====
// utv_if: valid/ready channel interfaces for text bytes, verdicts and config writes.
// Depends on utv_pkg for field types.
interface utv_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] text_byte;

  modport source (output valid, output start_req, output text_byte, input ready);
  modport sink   (input valid, input start_req, input text_byte, output ready);
endinterface

interface utv_out_if;
  logic              valid;
  logic              ready;
  logic              is_valid;
  logic [2:0]        verdict_reason;
  utv_pkg::pos_t     verdict_position;

  modport source (output valid, output is_valid, output verdict_reason,
                  output verdict_position, input ready);
  modport sink   (input valid, input is_valid, input verdict_reason,
                  input verdict_position, output ready);
endinterface

interface utv_cfg_if;
  logic          valid;
  logic          ready;
  logic [0:0]    reg_index;
  utv_pkg::pos_t reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== hw/rtl/utv_byte_check.sv =====
// utv_byte_check: per-byte decision logic, purely combinational.
// Depends on utv_pkg (check_t, reason codes, cont_count).
module utv_byte_check (
  input  utv_pkg::pos_t    pos,
  input  utv_pkg::pend_t   pend,
  input  logic [7:0]       text_byte,
  input  utv_pkg::pos_t    limit,
  input  utv_pkg::pos_t    min_length,
  output utv_pkg::check_t  result
);

  logic [utv_pkg::POS_W:0] pos_inc;
  logic [utv_pkg::POS_W:0] lead_end;
  utv_pkg::pend_t          n;
  logic                    is_ctrl;

  assign pos_inc  = {1'b0, pos} + {{utv_pkg::POS_W{1'b0}}, 1'b1};
  assign n        = utv_pkg::cont_count(text_byte);
  assign lead_end = {1'b0, pos} + {{(utv_pkg::POS_W - 2){1'b0}}, n};
  assign is_ctrl  = (text_byte < utv_pkg::CTRL_LIMIT) && (text_byte != utv_pkg::CHAR_TAB)
                    && (text_byte != utv_pkg::CHAR_LF) && (text_byte != utv_pkg::CHAR_CR);

  always_comb begin
    result           = '0;
    result.reason    = utv_pkg::REASON_OK;
    result.position  = pos;
    result.pend_next = pend;
    result.pos_next  = pos;
    if (pos >= limit) begin
      result.emit   = 1'b1;
      result.reason = utv_pkg::REASON_NOTERM;
    end else begin
      priority if (pend != 3'd0) begin
        if ((text_byte & utv_pkg::CONT_MASK) != utv_pkg::CONT_TAG) begin
          result.emit   = 1'b1;
          result.reason = utv_pkg::REASON_CONT;
        end else begin
          result.pend_next = pend - 3'd1;
        end
      end else if (text_byte == utv_pkg::CHAR_NUL) begin
        result.emit = 1'b1;
        if (pos >= min_length) begin
          result.ok     = 1'b1;
          result.reason = utv_pkg::REASON_OK;
        end else begin
          result.reason = utv_pkg::REASON_SHORT;
        end
      end else if (text_byte[7]) begin
        if ((text_byte & utv_pkg::CONT_MASK) != utv_pkg::LEAD_TAG || n == 3'd0) begin
          result.emit   = 1'b1;
          result.reason = utv_pkg::REASON_LEAD;
        end else if (lead_end >= {1'b0, limit}) begin
          result.emit   = 1'b1;
          result.reason = utv_pkg::REASON_OVERRUN;
        end else begin
          result.pend_next = n;
        end
      end else if (is_ctrl) begin
        result.emit   = 1'b1;
        result.reason = utv_pkg::REASON_CTRL;
      end else begin
        result.pend_next = pend;
      end

      if (!result.emit) begin
        result.pos_next = (pos == utv_pkg::POS_MAX) ? pos : pos_inc[utv_pkg::POS_W-1:0];
        if (pos_inc >= {1'b0, limit}) begin
          result.emit     = 1'b1;
          result.reason   = utv_pkg::REASON_NOTERM;
          result.position = pos_inc[utv_pkg::POS_W-1:0];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/utv_text_validator_core.sv =====
// utf8_text_validator_core: legacy UTF-8 check, one byte per cycle unless stalled.
// Depends on utv_pkg, utv_if (channel interfaces) and utv_byte_check.
//
//   channel      dir   beat payload
//   text_in      in    start_req, text_byte
//   verdict_out  out   is_valid, verdict_reason, verdict_position
//   cfg          in    reg_index, reg_data (min_length, max_length)
//
// One byte per cycle sustained unless a verdict stalls; an accepted byte passes
// through the input register, then decision logic into the verdict register.
// The position/pending-count loop closes through the combinational utv_byte_check.
// A stalled verdict holds; bytes that decide nothing keep flowing behind it.
// rst is synchronous; it clears all control state and restores the registers.
module utf8_text_validator_core #(
  parameter int unsigned MAX_SPAN = 65536
) (
  input logic       clk,
  input logic       rst,
  utv_in_if.sink    text_in,
  utv_out_if.source verdict_out,
  utv_cfg_if.sink   cfg
);

  localparam int unsigned POS_MAX_I = (1 << utv_pkg::POS_W) - 1;
  localparam int unsigned SPAN_CAP_I = (MAX_SPAN < POS_MAX_I) ? MAX_SPAN : POS_MAX_I;
  localparam utv_pkg::pos_t SPAN_CAP = SPAN_CAP_I[utv_pkg::POS_W-1:0];

  utv_pkg::pos_t   min_length;
  utv_pkg::pos_t   max_length;
  utv_pkg::pos_t   limit;

  logic            s1_valid;
  logic            s1_start;
  logic [7:0]      s1_byte;

  utv_pkg::pos_t   pos;
  utv_pkg::pend_t  pend;
  logic            done;

  utv_pkg::pos_t   eff_pos;
  utv_pkg::pend_t  eff_pend;
  logic            eff_done;
  utv_pkg::check_t chk;
  logic            s1_emit;
  logic            s1_go;
  logic            out_free;

  logic            out_valid;
  logic            out_ok;
  utv_pkg::reason_t out_reason;
  utv_pkg::pos_t   out_pos;

  assign limit = (max_length < SPAN_CAP) ? max_length : SPAN_CAP;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= '0;
      max_length <= utv_pkg::pos_t'(65536);
    end else if (cfg.valid) begin
      unique case (utv_pkg::cfg_reg_t'(cfg.reg_index))
        utv_pkg::REG_MIN_LENGTH: min_length <= cfg.reg_data;
        utv_pkg::REG_MAX_LENGTH: max_length <= cfg.reg_data;
        default: ;
      endcase
    end
  end

  assign eff_pos  = s1_start ? '0 : pos;
  assign eff_pend = s1_start ? '0 : pend;
  assign eff_done = s1_start ? 1'b0 : done;

  utv_byte_check u_check (
    .pos        (eff_pos),
    .pend       (eff_pend),
    .text_byte  (s1_byte),
    .limit      (limit),
    .min_length (min_length),
    .result     (chk)
  );

  assign s1_emit  = !eff_done && chk.emit;
  assign out_free = !out_valid || verdict_out.ready;
  assign s1_go    = s1_valid && (!s1_emit || out_free);
  assign text_in.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_in.ready) begin
      s1_valid <= text_in.valid;
    end
    if (text_in.ready && text_in.valid) begin
      s1_start <= text_in.start_req;
      s1_byte  <= text_in.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      pend <= '0;
      done <= 1'b0;
    end else if (s1_go) begin
      if (eff_done) begin
        pos  <= eff_pos;
        pend <= eff_pend;
        done <= 1'b1;
      end else begin
        pos  <= chk.pos_next;
        pend <= chk.pend_next;
        done <= chk.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid <= 1'b1;
    end else if (verdict_out.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && s1_emit) begin
      out_ok     <= chk.ok;
      out_reason <= chk.reason;
      out_pos    <= chk.position;
    end
  end

  assign verdict_out.valid            = out_valid;
  assign verdict_out.is_valid         = out_ok;
  assign verdict_out.verdict_reason   = out_reason;
  assign verdict_out.verdict_position = out_pos;

  a_emit_loads_out: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_emit |=> out_valid)
    else $error("verdict not loaded");

  a_emit_sets_done: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_emit |=> done)
    else $error("verdict given but text not closed");

  a_ok_matches_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ok == (out_reason == utv_pkg::REASON_OK)))
    else $error("is_valid disagrees with reason");

  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    pend <= 3'd5)
    else $error("pending continuation count out of range");

endmodule

// ===== verif/tb_utf8_text_validator_core.sv =====
// Self-checking bench for utf8_text_validator_core: a directed table of text bytes, then random
// texts under several length settings, each verdict checked against a local text-check model.
// Depends on utv_pkg and the utv_in_if, utv_out_if and utv_cfg_if channel interfaces.
module tb_utf8_text_validator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import utv_pkg::*;

  localparam int unsigned SPAN = 65536;
  localparam int unsigned PIPE_PAUSE = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned PHASE_BEATS = 200;
  localparam int unsigned N_PHASES = 9;

  typedef struct packed {
    logic    ok;
    reason_t reason;
    pos_t    position;
  } verdict_t;

  typedef enum logic {ROW_BEAT, ROW_CONFIG} row_kind_t;

  // config rows: pos = min_length, lim = max_length
  typedef struct {
    row_kind_t kind;
    logic      s;
    logic [7:0] b;
    bit        typed;
    bit        hit;
    logic      ok;
    reason_t   reason;
    pos_t      pos;
    pos_t      lim;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  utv_in_if  text_in();
  utv_out_if verdict_out();
  utv_cfg_if cfg();

  utf8_text_validator_core #(.MAX_SPAN(SPAN)) u_dut (
    .clk(clk),
    .rst(rst),
    .text_in(text_in),
    .verdict_out(verdict_out),
    .cfg(cfg)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic       beat_typed;
  logic       beat_hit;
  verdict_t   beat_want;
  bit         no_idle = 1'b0;
  bit         hold_go = 1'b0;

  verdict_t   verdicts_due[$];
  logic [7:0] text_bytes[$];
  row_t       plan[$];

  int unsigned txt_pos;
  int unsigned txt_pend;
  bit          txt_closed;
  int unsigned min_len;
  int unsigned max_len;

  int unsigned n_errors;
  int unsigned n_beats;
  int unsigned n_verdicts;
  int unsigned n_writes;
  int unsigned seen_reason [8];

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic int unsigned lead_span(input logic [7:0] b);
    casez (b)
      8'b110?????: return 1;
      8'b1110????: return 2;
      8'b11110???: return 3;
      8'b111110??: return 4;
      8'b1111110?: return 5;
      default:     return 0;
    endcase
  endfunction

  task automatic check_text_byte(input logic s, input logic [7:0] b,
                                 output bit hit, output verdict_t v);
    int unsigned lim;
    int unsigned at;
    int unsigned span;
    lim = (max_len < SPAN) ? max_len : SPAN;
    hit = 1'b0;
    v = '0;
    if (s) begin
      txt_pos = 0;
      txt_pend = 0;
      txt_closed = 1'b0;
    end
    if (txt_closed) return;
    at = txt_pos;
    if (at >= lim) begin
      hit = 1'b1;
      v = '{1'b0, REASON_NOTERM, pos_t'(at)};
    end else if (txt_pend != 0) begin
      if (b[7:6] != 2'b10) begin
        hit = 1'b1;
        v = '{1'b0, REASON_CONT, pos_t'(at)};
      end else begin
        txt_pend--;
      end
    end else if (b == CHAR_NUL) begin
      hit = 1'b1;
      if (at >= min_len) v = '{1'b1, REASON_OK, pos_t'(at)};
      else v = '{1'b0, REASON_SHORT, pos_t'(at)};
    end else if (b[7]) begin
      span = lead_span(b);
      if (span == 0) begin
        hit = 1'b1;
        v = '{1'b0, REASON_LEAD, pos_t'(at)};
      end else if (at + span >= lim) begin
        hit = 1'b1;
        v = '{1'b0, REASON_OVERRUN, pos_t'(at)};
      end else begin
        txt_pend = span;
      end
    end else if (b < CTRL_LIMIT && b != CHAR_TAB && b != CHAR_LF && b != CHAR_CR) begin
      hit = 1'b1;
      v = '{1'b0, REASON_CTRL, pos_t'(at)};
    end
    if (!hit) begin
      if (txt_pos < POS_MAX) txt_pos++;
      if (at + 1 >= lim) begin
        hit = 1'b1;
        v = '{1'b0, REASON_NOTERM, pos_t'(at + 1)};
      end
    end
    if (hit) txt_closed = 1'b1;
  endtask

  always @(posedge clk) begin
    bit       hit;
    verdict_t v;
    verdict_t want;
    if (!rst) begin
      if (verdict_out.valid && verdict_out.ready) begin
        n_verdicts++;
        seen_reason[verdict_out.verdict_reason]++;
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("verdict %0d arrived with none due", n_verdicts));
        end else begin
          want = verdicts_due.pop_front();
          if (verdict_out.is_valid !== want.ok)
            report_mismatch($sformatf("verdict %0d: is_valid %0b, expected %0b",
                                      n_verdicts, verdict_out.is_valid, want.ok));
          if (verdict_out.verdict_reason !== want.reason)
            report_mismatch($sformatf("verdict %0d: reason %0d, expected %s",
                                      n_verdicts, verdict_out.verdict_reason,
                                      want.reason.name()));
          if (verdict_out.verdict_position !== want.position)
            report_mismatch($sformatf("verdict %0d: position %0d, expected %0d",
                                      n_verdicts, verdict_out.verdict_position,
                                      want.position));
        end
      end
      if (cfg.valid && cfg.ready) begin
        n_writes++;
        case (cfg.reg_index)
          REG_MIN_LENGTH: min_len = cfg.reg_data;
          REG_MAX_LENGTH: max_len = cfg.reg_data;
          default: ;
        endcase
      end
      if (text_in.valid && text_in.ready) begin
        n_beats++;
        check_text_byte(text_in.start_req, text_in.text_byte, hit, v);
        if (beat_typed) begin
          if (beat_hit) verdicts_due.push_back(beat_want);
        end else if (hit) begin
          verdicts_due.push_back(v);
        end
      end
    end
  end

  initial begin
    int unsigned left;
    bit seen;
    left = 0;
    seen = 1'b0;
    verdict_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go != seen) begin
        seen = hold_go;
        left = HOLD_CYCLES;
      end
      if (left != 0) begin
        verdict_out.ready <= 1'b0;
        left--;
      end else begin
        verdict_out.ready <= no_idle || ($urandom_range(99) >= 33);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (text_in.valid && text_in.ready) || (cfg.valid && cfg.ready) ||
          (verdict_out.valid && verdict_out.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no beat for %0d cycles, %0d verdicts still due",
             QUIET_LIMIT, verdicts_due.size());
    $display("tb_utf8_text_validator_core: done, errors");
    $finish;
  end

  task automatic send_beat(input logic s, input logic [7:0] b, input bit typed,
                           input bit hit, input verdict_t want);
    while (!no_idle && $urandom_range(99) < 33) begin
      text_in.valid <= 1'b0;
      @(posedge clk);
    end
    text_in.valid     <= 1'b1;
    text_in.start_req <= s;
    text_in.text_byte <= b;
    beat_typed        <= typed;
    beat_hit          <= hit;
    beat_want         <= want;
    @(posedge clk);
    while (!text_in.ready) @(posedge clk);
  endtask

  task automatic wait_verdicts_out();
    text_in.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (PIPE_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input pos_t data);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.reg_data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic apply_config(input pos_t lo, input pos_t hi);
    wait_verdicts_out();
    write_reg(REG_MIN_LENGTH, lo);
    write_reg(REG_MAX_LENGTH, hi);
    cfg.valid <= 1'b0;
  endtask

  // mostly well-formed text with random content; some noise, broken sequences, no terminator
  task automatic compose_text(input int unsigned cap);
    int unsigned chars;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  lead;
    text_bytes.delete();
    chars = $urandom_range(cap, 1);
    while (text_bytes.size() < chars) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        text_bytes.push_back(8'($urandom_range(8'h7f, 8'h20)));
      end else if (pick < 50) begin
        case ($urandom_range(2))
          0:       text_bytes.push_back(CHAR_TAB);
          1:       text_bytes.push_back(CHAR_LF);
          default: text_bytes.push_back(CHAR_CR);
        endcase
      end else if (pick < 90) begin
        n = $urandom_range(5, 1);
        case (n)
          1:       lead = {3'b110, 5'($urandom)};
          2:       lead = {4'b1110, 4'($urandom)};
          3:       lead = {5'b11110, 3'($urandom)};
          4:       lead = {6'b111110, 2'($urandom)};
          default: lead = {7'b1111110, 1'($urandom)};
        endcase
        text_bytes.push_back(lead);
        repeat (n) begin
          if ($urandom_range(99) < 6) text_bytes.push_back(8'($urandom));
          else text_bytes.push_back({2'b10, 6'($urandom)});
        end
      end else begin
        text_bytes.push_back(8'($urandom));
      end
    end
    if ($urandom_range(99) < 85) text_bytes.push_back(CHAR_NUL);
  endtask

  int unsigned ph_min [N_PHASES] = '{0, 0, 5, 3, 0, 65536, 2, 0, 12};
  int unsigned ph_max [N_PHASES] = '{65536, 8, 16, 1, 0, 65536, 40, 2, 65536};

  initial begin
    int unsigned sent;
    int unsigned cap;
    bit          lead_start;
    bit          paused;

    n_errors = 0;
    n_beats = 0;
    n_verdicts = 0;
    n_writes = 0;
    foreach (seen_reason[r]) seen_reason[r] = 0;
    txt_pos = 0;
    txt_pend = 0;
    txt_closed = 1'b0;
    min_len = 0;
    max_len = SPAN;

    rst               <= 1'b1;
    text_in.valid     <= 1'b0;
    text_in.start_req <= 1'b0;
    text_in.text_byte <= 8'h00;
    cfg.valid         <= 1'b0;
    cfg.reg_index     <= REG_MIN_LENGTH;
    cfg.reg_data      <= '0;
    beat_typed        <= 1'b0;
    beat_hit          <= 1'b0;
    beat_want         <= '0;

    plan = '{
      '{ROW_BEAT,   1'b0, 8'h41, 1'b1, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'h00, 1'b1, 1'b1, 1'b1, REASON_OK,      17'd1, 17'd0},
      '{ROW_BEAT,   1'b0, 8'h41, 1'b1, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b1, 8'h00, 1'b1, 1'b1, 1'b1, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b1, 8'hff, 1'b1, 1'b1, 1'b0, REASON_LEAD,    17'd0, 17'd0},
      '{ROW_BEAT,   1'b1, 8'hfe, 1'b1, 1'b1, 1'b0, REASON_LEAD,    17'd0, 17'd0},
      '{ROW_BEAT,   1'b1, 8'h80, 1'b1, 1'b1, 1'b0, REASON_LEAD,    17'd0, 17'd0},
      '{ROW_BEAT,   1'b1, 8'h09, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'h0a, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'h0d, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'h1f, 1'b1, 1'b1, 1'b0, REASON_CTRL,    17'd3, 17'd0},
      '{ROW_BEAT,   1'b1, 8'hfd, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'h80, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'hbf, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'h80, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'hbf, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'h80, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'h00, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b1, 8'hc0, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'h00, 1'b1, 1'b1, 1'b0, REASON_CONT,    17'd1, 17'd0},
      '{ROW_CONFIG, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd3, 17'd4},
      '{ROW_BEAT,   1'b1, 8'h00, 1'b1, 1'b1, 1'b0, REASON_SHORT,   17'd0, 17'd0},
      '{ROW_BEAT,   1'b1, 8'hf8, 1'b1, 1'b1, 1'b0, REASON_OVERRUN, 17'd0, 17'd0},
      '{ROW_BEAT,   1'b1, 8'h41, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'h42, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'h43, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b0, 8'h44, 1'b1, 1'b1, 1'b0, REASON_NOTERM,  17'd4, 17'd0},
      '{ROW_CONFIG, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, REASON_OK,      17'd0, 17'd0},
      '{ROW_BEAT,   1'b1, 8'h00, 1'b1, 1'b1, 1'b0, REASON_NOTERM,  17'd0, 17'd0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CONFIG)
        apply_config(plan[i].pos, plan[i].lim);
      else
        send_beat(plan[i].s, plan[i].b, plan[i].typed, plan[i].hit,
                  '{plan[i].ok, plan[i].reason, plan[i].pos});
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      apply_config(pos_t'(ph_min[ph]), pos_t'(ph_max[ph]));
      no_idle = (ph == 0);
      cap = (ph_max[ph] < 30) ? ph_max[ph] + 2 : 24;
      sent = 0;
      paused = 1'b0;
      // hold the verdict side while one-byte texts pile up behind it
      if (ph == 2) begin
        hold_go = !hold_go;
        repeat (40) begin
          send_beat(1'b1, CHAR_NUL, 1'b0, 1'b0, '0);
          sent++;
        end
      end
      while (sent < PHASE_BEATS) begin
        if (ph == 6 && !paused && sent >= PHASE_BEATS / 2) begin
          wait_verdicts_out();
          paused = 1'b1;
        end
        compose_text(cap);
        lead_start = ($urandom_range(99) < 92);
        foreach (text_bytes[k])
          send_beat((k == 0) ? lead_start : 1'b0, text_bytes[k], 1'b0, 1'b0, '0);
        sent += text_bytes.size();
      end
    end
    no_idle = 1'b0;

    wait_verdicts_out();

    $display("run covered %0d text bytes, %0d verdicts, %0d register writes over %0d settings",
             n_beats, n_verdicts, n_writes, N_PHASES + 3);
    $display({"verdicts by reason: ok %0d short %0d lead %0d overrun %0d",
              " cont %0d ctrl %0d noterm %0d"},
             seen_reason[REASON_OK], seen_reason[REASON_SHORT], seen_reason[REASON_LEAD],
             seen_reason[REASON_OVERRUN], seen_reason[REASON_CONT], seen_reason[REASON_CTRL],
             seen_reason[REASON_NOTERM]);
    if (n_errors == 0)
      $display("tb_utf8_text_validator_core: done, clean");
    else
      $display("tb_utf8_text_validator_core: done, errors");
    $finish;
  end

endmodule
